/* rtl/core/tsdf_pkg.sv */
// ----------------------------------------------------------------------------
// tsdf_pkg
// Shared types and constants of the text stream display filter.
// ----------------------------------------------------------------------------
package tsdf_pkg;

    localparam int NUMBER_DIGITS_DEFAULT = 6;
    localparam int COUNTER_DIGITS        = 6;
    localparam int QUEUE_DEPTH           = 4;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [23:0] COUNT_RESET = 24'h000001;

    typedef enum logic [1:0] {
        PFX_NONE       = 2'd0,
        PFX_CARET      = 2'd1,
        PFX_META       = 2'd2,
        PFX_META_CARET = 2'd3
    } pfx_t;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic show_ends;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    typedef struct packed {
        logic                          number;
        logic [4*COUNTER_DIGITS-1:0]   count;
        logic                          dollar;
        pfx_t                          pfx;
        logic [7:0]                    chr;
    } entry_t;

endpackage

/* rtl/core/tsdf_front.sv */
// ----------------------------------------------------------------------------
// tsdf_front
// Accepts raw bytes, tracks line state and the BCD line counter, and
// classifies each byte into a request for the output sequencer.
// ----------------------------------------------------------------------------
module tsdf_front
    import tsdf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       q_push,
    output entry_t     q_data,
    input  logic       q_full
);

    localparam int LIVE = (NUMBER_DIGITS < COUNTER_DIGITS) ? NUMBER_DIGITS : COUNTER_DIGITS;

    logic                        last_nl_reg;
    logic                        before_nl_reg;
    logic [4*COUNTER_DIGITS-1:0] count_reg;
    logic [4*COUNTER_DIGITS-1:0] count_next;

    logic       accept;
    logic       is_nl;
    logic       drop;
    logic       escape;
    logic       all_nine;
    logic       carry;
    logic [3:0] dig;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_nl    = (s_tdata == CH_NL);
    assign drop     = cfg.squeeze_blank && is_nl && last_nl_reg && before_nl_reg;
    assign escape   = cfg.show_nonprinting || cfg.show_ends;
    assign q_push   = accept && !drop;

    always_comb
    begin
        q_data        = '0;
        q_data.count  = count_reg;
        q_data.number = last_nl_reg && (cfg.number_nonblank ? !is_nl : cfg.number_all);
        q_data.dollar = cfg.show_ends && is_nl;
        q_data.pfx    = PFX_NONE;
        q_data.chr    = s_tdata;
        if (cfg.show_tabs && s_tdata == CH_TAB)
        begin
            q_data.pfx = PFX_CARET;
            q_data.chr = CH_I;
        end
        else if (escape && s_tdata != CH_TAB && !is_nl
                 && !(s_tdata >= 8'd32 && s_tdata < 8'd127))
        begin
            if (s_tdata == CH_DEL)
            begin
                q_data.pfx = PFX_CARET;
                q_data.chr = CH_QMARK;
            end
            else if (s_tdata >= 8'd160)
            begin
                if (s_tdata == 8'd255)
                begin
                    q_data.pfx = PFX_META_CARET;
                    q_data.chr = CH_QMARK;
                end
                else
                begin
                    q_data.pfx = PFX_META;
                    q_data.chr = s_tdata - 8'd128;
                end
            end
            else if (s_tdata >= 8'd128)
            begin
                q_data.pfx = PFX_META_CARET;
                q_data.chr = s_tdata - 8'd64;
            end
            else
            begin
                q_data.pfx = PFX_CARET;
                q_data.chr = s_tdata + 8'd64;
            end
        end
    end

    // bcd increment over the live digits, saturating at all nines
    always_comb
    begin
        all_nine   = 1'b1;
        carry      = 1'b1;
        dig        = '0;
        count_next = count_reg;
        for (int k = 0; k < LIVE; k++)
        begin
            dig = count_reg[4*k +: 4];
            if (dig != 4'd9)
            begin
                all_nine = 1'b0;
            end
            if (carry)
            begin
                if (dig >= 4'd9)
                begin
                    count_next[4*k +: 4] = 4'd0;
                end
                else
                begin
                    count_next[4*k +: 4] = dig + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine)
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_nl_reg   <= 1'b1;
            before_nl_reg <= 1'b0;
            count_reg     <= COUNT_RESET[4*COUNTER_DIGITS-1:0];
        end
        else if (q_push)
        begin
            before_nl_reg <= last_nl_reg;
            last_nl_reg   <= is_nl;
            if (q_data.number)
            begin
                count_reg <= count_next;
            end
        end
    end

endmodule

/* rtl/core/tsdf_queue.sv */
// ----------------------------------------------------------------------------
// tsdf_queue
// Short register queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module tsdf_queue
    import tsdf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/tsdf_back.sv */
// ----------------------------------------------------------------------------
// tsdf_back
// Output sequencer: expands queue head into line number, tab, dollar, escape
// prefix and final byte to an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tsdf_back
    import tsdf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     q_data,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    localparam int LIVE  = (NUMBER_DIGITS < COUNTER_DIGITS) ? NUMBER_DIGITS : COUNTER_DIGITS;
    localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    typedef enum logic [4:0] {
        PH_NUM    = 5'b00001,
        PH_TAB    = 5'b00010,
        PH_DOLLAR = 5'b00100,
        PH_PFX    = 5'b01000,
        PH_CHAR   = 5'b10000
    } phase_t;

    logic             busy_reg;
    phase_t           phase_reg;
    logic [DIG_W-1:0] dig_reg;
    logic             started_reg;
    logic [1:0]       pfx_idx_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;

    phase_t           cur_phase;
    phase_t           next_phase;
    phase_t           after_dollar;
    logic [DIG_W-1:0] cur_dig;
    logic             cur_started;
    logic             started;
    logic [1:0]       cur_pfx_idx;
    logic             pfx_done;
    logic [3:0]       digits [NUMBER_DIGITS];
    logic [3:0]       dig;
    logic [7:0]       byte_out;
    logic             emit;

    assign emit     = !q_empty && (!out_valid_reg || m_tready);
    assign q_pop    = emit && (cur_phase == PH_CHAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        for (int p = 0; p < NUMBER_DIGITS; p++)
        begin
            digits[p] = 4'd0;
        end
        for (int p = 0; p < LIVE; p++)
        begin
            digits[p] = q_data.count[4*p +: 4];
        end
    end

    always_comb
    begin
        after_dollar = (q_data.pfx != PFX_NONE) ? PH_PFX : PH_CHAR;
        if (busy_reg)
        begin
            cur_phase   = phase_reg;
            cur_dig     = dig_reg;
            cur_started = started_reg;
            cur_pfx_idx = pfx_idx_reg;
        end
        else
        begin
            cur_dig     = DIG_W'(NUMBER_DIGITS - 1);
            cur_started = 1'b0;
            cur_pfx_idx = 2'd0;
            if (q_data.number)
            begin
                cur_phase = PH_NUM;
            end
            else if (q_data.dollar)
            begin
                cur_phase = PH_DOLLAR;
            end
            else
            begin
                cur_phase = after_dollar;
            end
        end

        dig     = digits[cur_dig];
        started = cur_started || (dig != 4'd0) || (cur_dig == '0);

        case (q_data.pfx)
            PFX_CARET: pfx_done = 1'b1;
            PFX_META:  pfx_done = (cur_pfx_idx == 2'd1);
            default:   pfx_done = (cur_pfx_idx == 2'd2);
        endcase

        byte_out   = q_data.chr;
        next_phase = PH_CHAR;
        case (cur_phase)
            PH_NUM:
            begin
                byte_out   = started ? (CH_ZERO + {4'd0, dig}) : CH_SPACE;
                next_phase = (cur_dig == '0) ? PH_TAB : PH_NUM;
            end
            PH_TAB:
            begin
                byte_out   = CH_TAB;
                next_phase = q_data.dollar ? PH_DOLLAR : after_dollar;
            end
            PH_DOLLAR:
            begin
                byte_out   = CH_DOLLAR;
                next_phase = after_dollar;
            end
            PH_PFX:
            begin
                if (q_data.pfx == PFX_CARET || cur_pfx_idx == 2'd2)
                begin
                    byte_out = CH_CARET;
                end
                else if (cur_pfx_idx == 2'd0)
                begin
                    byte_out = CH_M;
                end
                else
                begin
                    byte_out = CH_DASH;
                end
                next_phase = pfx_done ? PH_CHAR : PH_PFX;
            end
            default:
            begin
                byte_out   = q_data.chr;
                next_phase = PH_CHAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_CHAR;
            dig_reg     <= '0;
            started_reg <= 1'b0;
            pfx_idx_reg <= 2'd0;
        end
        else if (emit)
        begin
            if (cur_phase == PH_CHAR)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                busy_reg    <= 1'b1;
                phase_reg   <= next_phase;
                dig_reg     <= (cur_phase == PH_NUM) ? cur_dig - 1'b1 : cur_dig;
                started_reg <= (cur_phase == PH_NUM) ? started : cur_started;
                pfx_idx_reg <= (cur_phase == PH_PFX) ? cur_pfx_idx + 2'd1 : cur_pfx_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= byte_out;
            out_last_reg <= (cur_phase == PH_CHAR);
        end
    end

endmodule

/* rtl/core/text_stream_display_filter.sv */
// ----------------------------------------------------------------------------
// text_stream_display_filter
// Turns a raw byte stream into its displayed form: line numbers, shown
// line ends and tabs, squeezed blank lines and escaped non-printing bytes.
//
//   channel   direction  handshake               payload
//   s_axis    in         s_axis_tvalid/tready    tdata: in_byte
//   m_axis    out        m_axis_tvalid/tready    tdata: out_byte, tlast: last_of_run
//   cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data bit 0
//
// one output byte per cycle from the sequencer unless m_axis stalls; an input byte
// expands into 1 to NUMBER_DIGITS + 5 output bytes
// the front takes one byte per cycle while the 4-entry queue has room
// a squeezed newline is accepted and gives no output
// reset restarts line state and counter, empties the queue and clears output valid at once
// ----------------------------------------------------------------------------
module text_stream_display_filter
    import tsdf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // in_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,  // out_byte
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg;
    logic   q_push;
    logic   q_pop;
    logic   q_empty;
    logic   q_full;
    entry_t q_wr_data;
    entry_t q_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data[0];
                CFG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data[0];
                CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data[0];
                CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data[0];
                CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data[0];
                CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data[0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    tsdf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .q_push   (q_push),
        .q_data   (q_wr_data),
        .q_full   (q_full)
    );

    tsdf_queue #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    tsdf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_rd_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("queue read while empty");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (m_axis_tvalid && m_axis_tlast))
        else $error("finished request did not end with a last byte");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (s_axis_tvalid && s_axis_tready))
        else $error("queue written without an accepted byte");

endmodule
